### sv/lpfd_pkg.sv
package lpfd_pkg;

   localparam int unsigned MAX_FRAME    = 4096;
   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned POS_W        = 13;
   localparam int unsigned PLEN_W       = 12;
   localparam int unsigned TDATA_W      = 56;

   localparam logic [31:0] MAX_FRAME_WORD = 32'(MAX_FRAME);
   localparam logic [31:0] HEADER_WORD    = 32'(HEADER_BYTES);
   localparam logic [31:0] PLEN_MAX       = 32'((1 << PLEN_W) - 1);

   typedef struct packed {
      logic [31:0]       protocol_id;
      logic [PLEN_W-1:0] payload_length;
      logic [7:0]        data_byte;
      logic              has_byte;
      logic              last;
   } result_type;

   function automatic logic [31:0] put_byte(input logic [31:0] word,
                                            input logic [1:0]  lane,
                                            input logic [7:0]  b);
      logic [31:0] w;
      w = word;
      case (lane)
         2'd0:    w[7:0]   = b;
         2'd1:    w[15:8]  = b;
         2'd2:    w[23:16] = b;
         default: w[31:24] = b;
      endcase
      return w;
   endfunction

endpackage

### sv/lpfd_parser.sv
module lpfd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic                   end_of_read,
   output logic                   result_valid,
   output lpfd_pkg::result_type   result
);

   logic [lpfd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [31:0]                len_ff, len_in;
   logic [31:0]                seq_ff, seq_in;
   logic [31:0]                proto_ff, proto_in;
   logic [31:0]                last_num_ff, last_num_in;
   logic                       accepted_ff, accepted_in;
   logic                       discard_ff, discard_in;

   logic [lpfd_pkg::POS_W-1:0] pos_next;
   logic [lpfd_pkg::POS_W:0]   pos_plus;
   logic [31:0]                plen;
   logic                       fin;

   assign pos_plus = {1'b0, pos_ff} + 1'b1;
   assign pos_next = pos_plus[lpfd_pkg::POS_W-1:0];
   assign fin      = 32'(pos_plus) >= len_ff;

   always_comb begin
      plen = len_ff - lpfd_pkg::HEADER_WORD;
      if (plen > lpfd_pkg::PLEN_MAX) begin
         plen = lpfd_pkg::PLEN_MAX;
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      len_in       = len_ff;
      seq_in       = seq_ff;
      proto_in     = proto_ff;
      last_num_in  = last_num_ff;
      accepted_in  = accepted_ff;
      discard_in   = discard_ff;
      result_valid = 1'b0;
      result.protocol_id    = proto_ff;
      result.payload_length = plen[lpfd_pkg::PLEN_W-1:0];
      result.data_byte      = rx_byte;
      result.has_byte       = 1'b1;
      result.last           = fin;
      if (discard_ff) begin
         if (end_of_read) begin
            discard_in = 1'b0;
            pos_in     = '0;
         end
      end else if (pos_ff < 13'd4) begin
         len_in = lpfd_pkg::put_byte(len_ff, pos_ff[1:0], rx_byte);
         pos_in = pos_next;
         if (pos_ff == 13'd3 &&
             (len_in > lpfd_pkg::MAX_FRAME_WORD || len_in < lpfd_pkg::HEADER_WORD)) begin
            pos_in     = '0;
            discard_in = !end_of_read;
         end
      end else if (pos_ff < 13'd8) begin
         seq_in = lpfd_pkg::put_byte(seq_ff, pos_ff[1:0], rx_byte);
         pos_in = pos_next;
         if (pos_ff == 13'd7) begin
            accepted_in = seq_in > last_num_ff;
            if (seq_in > last_num_ff) begin
               last_num_in = seq_in;
            end
         end
      end else if (pos_ff < 13'(lpfd_pkg::HEADER_BYTES)) begin
         proto_in = lpfd_pkg::put_byte(proto_ff, pos_ff[1:0], rx_byte);
         pos_in   = pos_next;
         if (pos_ff == 13'(lpfd_pkg::HEADER_BYTES - 1) && len_ff == lpfd_pkg::HEADER_WORD) begin
            pos_in                = '0;
            result_valid          = accepted_ff;
            result.protocol_id    = proto_in;
            result.data_byte      = '0;
            result.has_byte       = 1'b0;
            result.last           = 1'b1;
         end
      end else begin
         pos_in       = fin ? '0 : pos_next;
         result_valid = accepted_ff;
      end
      result_valid = result_valid & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         len_ff      <= '0;
         seq_ff      <= '0;
         proto_ff    <= '0;
         last_num_ff <= '0;
         accepted_ff <= 1'b0;
         discard_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         seq_ff      <= seq_in;
         proto_ff    <= proto_in;
         last_num_ff <= last_num_in;
         accepted_ff <= accepted_in;
         discard_ff  <= discard_in;
      end
   end

endmodule

### sv/lpfd_out_stage.sv
module lpfd_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic                              result_valid,
   input  lpfd_pkg::result_type              result,
   output logic                              space,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lpfd_pkg::TDATA_W-1:0]      rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   logic                 valid_ff, valid_in;
   lpfd_pkg::result_type data_ff;

   assign space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      if (load) begin
         valid_in = result_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result_valid) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0, data_ff.data_byte, data_ff.payload_length, data_ff.protocol_id};
   assign rsp_tuser  = data_ff.has_byte;
   assign rsp_tlast  = data_ff.last;

endmodule

### sv/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer.
// Request channel (req_): one received byte per request in tdata, tlast set
// on the final byte of a receive chunk. Each frame opens with three
// little-endian 32-bit words: total length, sequence number, protocol id.
// Response channel (rsp_): one response per payload byte of an accepted
// frame, carrying protocol id, payload length and the byte; tuser is set
// when the byte is present (clear for the single response of an empty
// payload) and tlast marks the final response of the frame. Frames with a
// bad length drop the rest of the chunk; frames with a stale sequence
// number are dropped without response.
// A response is registered and appears on rsp_ in the cycle after its
// request is taken. Throughput: one request per cycle unless rsp_ stalls,
// set by the parse step between frame state and response registers.
// Reset clears all frame state and the last accepted sequence number.
// While a response waits with rsp_tready low, req_tready falls and
// requests are held off; a taken response frees the register in the same
// cycle, so a new request is accepted alongside it.
module length_prefixed_frame_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // rx_byte
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lpfd_pkg::TDATA_W-1:0]  rsp_tdata,  // protocol_id, payload_length, data_byte
   output logic                          rsp_tuser,  // has_byte
   output logic                          rsp_tlast
);

   logic                 accept;
   logic                 space;
   logic                 result_valid;
   lpfd_pkg::result_type result;

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   lpfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_tdata),
      .end_of_read  (req_tlast),
      .result_valid (result_valid),
      .result       (result)
   );

   lpfd_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .result_valid (result_valid),
      .result       (result),
      .space        (space),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

### tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1800;
   localparam int PLEN_LSB     = 32;
   localparam int BYTE_LSB     = 32 + lpfd_pkg::PLEN_W;
   localparam int PAD_LSB      = BYTE_LSB + 8;
   localparam int HOLD_CYCLES  = 300;

   class frame_board;
      logic [lpfd_pkg::POS_W-1:0] pos;
      logic [31:0]                length_word;
      logic [31:0]                seq_word;
      logic [31:0]                proto_word;
      logic [31:0]                last_seq;
      bit                         accepted;
      bit                         discarding;
      lpfd_pkg::result_type       awaited[$];
      int                         errors;

      function new();
         pos         = '0;
         length_word = '0;
         seq_word    = '0;
         proto_word  = '0;
         last_seq    = '0;
         accepted    = 0;
         discarding  = 0;
         errors      = 0;
      endfunction

      function void add_result(logic [7:0] b, bit has, bit fin);
         lpfd_pkg::result_type r;
         logic [31:0] plen;
         plen = length_word - lpfd_pkg::HEADER_WORD;
         if (plen > lpfd_pkg::PLEN_MAX) plen = lpfd_pkg::PLEN_MAX;
         r.protocol_id    = proto_word;
         r.payload_length = plen[lpfd_pkg::PLEN_W-1:0];
         r.data_byte      = has ? b : 8'h00;
         r.has_byte       = has;
         r.last           = fin;
         awaited.push_back(r);
      endfunction

      function void take_byte(logic [7:0] b, logic eor);
         bit fin;
         if (discarding) begin
            if (eor) begin
               discarding = 0;
               pos        = '0;
            end
         end else if (pos < 4) begin
            length_word[8*pos[1:0] +: 8] = b;
            if (pos == 3 && (length_word > lpfd_pkg::MAX_FRAME_WORD ||
                             length_word < lpfd_pkg::HEADER_WORD)) begin
               pos        = '0;
               discarding = !eor;
            end else begin
               pos = pos + 13'd1;
            end
         end else if (pos < 8) begin
            seq_word[8*pos[1:0] +: 8] = b;
            if (pos == 7) begin
               accepted = seq_word > last_seq;
               if (accepted) last_seq = seq_word;
            end
            pos = pos + 13'd1;
         end else if (pos < lpfd_pkg::HEADER_BYTES) begin
            proto_word[8*pos[1:0] +: 8] = b;
            if (pos == lpfd_pkg::HEADER_BYTES - 1 && length_word == lpfd_pkg::HEADER_WORD) begin
               pos = '0;
               if (accepted) add_result(8'h00, 1'b0, 1'b1);
            end else begin
               pos = pos + 13'd1;
            end
         end else begin
            fin = (32'(pos) + 1) >= length_word;
            pos = fin ? '0 : pos + 13'd1;
            if (accepted) add_result(b, 1'b1, fin);
         end
      endfunction

      function void compare(string name, logic [31:0] exp, logic [31:0] act);
         if (act !== exp) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, exp, act);
         end
      endfunction

      function void match_response(logic [lpfd_pkg::TDATA_W-1:0] data, logic has, logic fin);
         lpfd_pkg::result_type e;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected response expected none actual %h/%b/%b",
                     $time, data, has, fin);
            return;
         end
         e = awaited.pop_front();
         compare("protocol_id", e.protocol_id, data[31:0]);
         compare("payload_length", 32'(e.payload_length), 32'(data[BYTE_LSB-1:PLEN_LSB]));
         compare("data_byte", 32'(e.data_byte), 32'(data[PAD_LSB-1:BYTE_LSB]));
         compare("tdata padding", 32'h0, 32'(data[lpfd_pkg::TDATA_W-1:PAD_LSB]));
         compare("has_byte", 32'(e.has_byte), 32'(has));
         compare("last", 32'(e.last), 32'(fin));
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [7:0]                   req_tdata;  // rx_byte
   logic                         req_tlast;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [lpfd_pkg::TDATA_W-1:0] rsp_tdata;  // protocol_id, payload_length, data_byte
   logic                         rsp_tuser;  // has_byte
   logic                         rsp_tlast;

   frame_board board = new();
   int  sent_count  = 0;
   int  taken_count = 0;
   int  rsp_count   = 0;
   int  awaited     = 0;
   bit  no_idle     = 0;
   bit  held        = 0;

   length_prefixed_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            board.match_response(rsp_tdata, rsp_tuser, rsp_tlast);
            rsp_count++;
         end
         if (req_tvalid && req_tready) begin
            board.take_byte(req_tdata, req_tlast);
            taken_count++;
         end
         awaited = board.awaited.size();
      end
   end

   function automatic bit chunk_end();
      return $urandom_range(0, 11) == 0;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eor);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eor;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic settle();
      wait (taken_count == sent_count);
   endtask

   // push the parser back to the start of a frame
   task automatic realign();
      settle();
      while (board.discarding || board.pos != 0) begin
         if (board.discarding) send_byte(8'($urandom), 1'b1);
         else if (board.pos < 4) send_byte(8'h00, 1'b1);
         else send_byte(8'($urandom), 1'b0);
         settle();
      end
   endtask

   task automatic send_frame(input logic [31:0] len, input logic [31:0] seq,
                             input logic [31:0] proto, input int npay);
      logic [31:0] word;
      for (int k = 0; k < 12; k++) begin
         word = k < 4 ? len : (k < 8 ? seq : proto);
         send_byte(word[8*(k%4) +: 8], chunk_end());
      end
      for (int k = 0; k < npay; k++) send_byte(8'($urandom), chunk_end());
   endtask

   task automatic send_bad_length(input logic [31:0] len, input bit cut);
      for (int k = 0; k < 3; k++) send_byte(len[8*k +: 8], chunk_end());
      send_byte(len[31:24], cut);
      if (!cut) begin
         repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0);
         send_byte(8'($urandom), 1'b1);
      end
      realign();
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 20)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      realign();
   endtask

   function automatic logic [31:0] bad_length();
      case ($urandom_range(0, 2))
         0:       return $urandom_range(0, 11);
         1:       return $urandom_range(lpfd_pkg::MAX_FRAME + 1, 65535);
         default: return $urandom | 32'h0001_0000;
      endcase
   endfunction

   always begin
      int stall;
      @(posedge clock);
      if (!held && rsp_count >= 100) begin
         held = 1;
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
      end
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_tready <= 1'b1;
      @(posedge clock);
      while (!rsp_tvalid) @(posedge clock);
   end

   initial begin
      int          npay;
      logic [31:0] last;
      logic [31:0] seq;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_frame(lpfd_pkg::HEADER_WORD, 32'd1, 32'hFFFF_FFFF, 0);
      send_frame(lpfd_pkg::HEADER_WORD + 1, 32'd1, 32'h0000_0000, 1);
      send_frame(lpfd_pkg::HEADER_WORD + 1, 32'd2, 32'h8000_0001, 1);
      send_bad_length(32'd11, 1'b1);
      send_bad_length(lpfd_pkg::MAX_FRAME_WORD + 1, 1'b0);
      send_bad_length(32'hFFFF_FFFF, 1'b0);

      while (sent_count < RANDOM_ITEMS) begin
         no_idle = $urandom_range(0, 5) == 0;
         settle();
         last = board.last_seq;
         npay = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
         if ($urandom_range(0, 6) == 0) seq = $urandom_range(0, last);
         else seq = last + $urandom_range(1, 1000);
         case ($urandom_range(0, 19))
            0, 1:    send_bad_length(bad_length(), $urandom_range(0, 1));
            2:       send_noise();
            default: send_frame(npay + lpfd_pkg::HEADER_BYTES, seq, $urandom, npay);
         endcase
      end
      send_frame(lpfd_pkg::HEADER_WORD + 3, 32'hFFFF_FFFF, $urandom, 3);
      send_frame(lpfd_pkg::HEADER_WORD + 2, 32'hFFFF_FFFF, $urandom, 2);

      req_tvalid <= 1'b0;
      settle();
      wait (awaited == 0);
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
